/* src/mcsp_pkg.sv */
// Shared types and constants for the multi-channel servo PWM block.
`default_nettype none

package mcsp_pkg;

    // Field widths.
    localparam int ANGLE_W  = 8;
    localparam int ONTIME_W = 16;
    localparam int TIME_W   = 20;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;

    // Widths of the angle mapping datapath.
    localparam int DIFF_A_W = ANGLE_W + 1;
    localparam int DIFF_B_W = ONTIME_W + 1;
    localparam int PROD_W   = DIFF_A_W + DIFF_B_W;
    localparam int DIV_W    = 24;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int DEFAULT_NUM_CHANNELS = 3;
    localparam int MAX_NUM_CHANNELS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd4;

    // Configuration reset values.
    localparam logic [ANGLE_W-1:0]  RST_MIN_ANGLE    = 8'd0;
    localparam logic [ANGLE_W-1:0]  RST_MAX_ANGLE    = 8'd180;
    localparam logic [ONTIME_W-1:0] RST_MIN_ON_TIME  = 16'd500;
    localparam logic [ONTIME_W-1:0] RST_MAX_ON_TIME  = 16'd2500;
    localparam logic [TIME_W-1:0]   RST_FRAME_PERIOD = 20'd20000;

    // Fixed pulse used for a zero angle.
    localparam logic [TIME_W-1:0] ZERO_ANGLE_ON  = 20'd500;
    localparam logic [TIME_W-1:0] ZERO_ANGLE_OFF = 20'd23500;

    // Command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef struct packed {
        logic         command;
        logic [1:0]   channel;
        logic [7:0]   angle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]   pwm_levels;
        logic [2:0]   toggled;
        logic         clipped;
    } t_out_item;

    // Control from the sequencer to the channel store.
    typedef struct packed {
        logic              tick;
        logic              set;
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
    } t_chan_cmd;

endpackage

`default_nettype wire

/* src/mcsp_div.sv */
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
`default_nettype none

module mcsp_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [mcsp_pkg::DIV_W-1:0]        i_dividend,
    input  wire logic [mcsp_pkg::ANGLE_W-1:0]      i_divisor,
    output logic      [mcsp_pkg::DIV_W-1:0]        o_quotient,
    output logic                                   o_done,
    output logic                                   o_busy
);

    localparam int DW = mcsp_pkg::DIV_W;
    localparam int AW = mcsp_pkg::ANGLE_W;

    logic                           r_busy;
    logic                           r_done;
    logic [mcsp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [AW-1:0]                  r_rem;
    logic [AW-1:0]                  r_div;
    logic [DW-1:0]                  r_quo;

    logic [AW:0]   rem_sh;
    logic          ge;
    logic [AW-1:0] n_rem;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        if (ge) begin
            n_rem = AW'(rem_sh - {1'b0, r_div});
        end else begin
            n_rem = rem_sh[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // The quotient is complete the cycle after the last step.
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mcsp_pkg::DIV_CNT_W'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
    assign o_busy     = r_busy;

endmodule

`default_nettype wire

/* src/mcsp_chan.sv */
// Per-channel timing store with the shared tick compare and update.
`default_nettype none

module mcsp_chan #(
    parameter int NUM_CHANNELS = mcsp_pkg::DEFAULT_NUM_CHANNELS,
    parameter int IW = 2
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [IW-1:0]             i_idx,
    input  wire mcsp_pkg::t_chan_cmd       i_cmd,
    output logic      [NUM_CHANNELS-1:0]   o_levels,
    output logic                           o_toggle
);

    localparam int TW = mcsp_pkg::TIME_W;

    logic [TW-1:0]           r_high    [NUM_CHANNELS];
    logic [TW-1:0]           r_low     [NUM_CHANNELS];
    logic [TW-1:0]           r_elapsed [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_level;

    logic [TW:0]   next_cnt;
    logic [TW-1:0] phase_len;

    // Compare the incremented count against the current phase length.
    always_comb begin
        next_cnt  = {1'b0, r_elapsed[i_idx]} + 1'b1;
        phase_len = r_level[i_idx] ? r_high[i_idx] : r_low[i_idx];
        o_toggle  = (next_cnt > {1'b0, phase_len});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_high[i]    <= '0;
                r_low[i]     <= '0;
                r_elapsed[i] <= '0;
            end
            r_level <= '0;
        end else if (i_cmd.tick) begin
            if (o_toggle) begin
                r_level[i_idx]   <= ~r_level[i_idx];
                r_elapsed[i_idx] <= '0;
            end else begin
                r_elapsed[i_idx] <= next_cnt[TW-1:0];
            end
        end else if (i_cmd.set) begin
            r_high[i_idx] <= i_cmd.high_time;
            r_low[i_idx]  <= i_cmd.low_time;
        end
    end

    assign o_levels = r_level;

endmodule

`default_nettype wire

/* src/multi_channel_servo_pwm_top.sv */
// Top level of the multi-channel servo PWM block: sequencer, registers and output stage.
`default_nettype none

// A tick word sweeps the channels one per cycle through a shared compare and
// update; after the last channel, the write-back state loads its result into
// the output register once that register is free, and the block is ready
// again. A set-angle word forms (angle - min_angle) * (max_on - min_on) in
// the multiply state and divides by the angle range in a shared restoring
// divider that yields one quotient bit per cycle; the divider is started from
// a set-up state and followed by saturation and write-back states. Angle zero,
// an out-of-range channel and a zero angle range skip the divider. The block
// takes one input word at a time; a finished result sits in an output
// register, and the next word may be accepted while that result waits.
// Configuration writes take effect at once and belong in idle time.
module multi_channel_servo_pwm_top #(
    parameter int NUM_CHANNELS = mcsp_pkg::DEFAULT_NUM_CHANNELS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire mcsp_pkg::t_in_item               i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output mcsp_pkg::t_out_item                   o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [mcsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mcsp_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int IW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TW  = mcsp_pkg::TIME_W;
    localparam int AW  = mcsp_pkg::ANGLE_W;
    localparam int OW  = mcsp_pkg::ONTIME_W;
    localparam int PW  = mcsp_pkg::PROD_W;
    localparam int DW  = mcsp_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_FIN,
        S_WB
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [AW-1:0] r_min_angle;
    logic [AW-1:0] r_max_angle;
    logic [OW-1:0] r_min_on;
    logic [OW-1:0] r_max_on;
    logic [TW-1:0] r_frame;

    // Work registers.
    logic [IW-1:0]           r_idx;
    logic [AW-1:0]           r_angle;
    logic [NUM_CHANNELS-1:0] r_tog;
    logic                    r_clip;
    logic signed [PW-1:0]    r_prod;
    logic                    r_neg;
    logic signed [PW-1:0]    r_on;
    logic [TW-1:0]           r_wr_high;
    logic [TW-1:0]           r_wr_low;
    logic                    r_wr_en;

    // Output stage.
    logic                    r_out_valid;
    mcsp_pkg::t_out_item     r_out;

    // Channel store interface.
    mcsp_pkg::t_chan_cmd     chan_cmd;
    logic [NUM_CHANNELS-1:0] chan_levels;
    logic                    chan_toggle;

    // Divider interface.
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [AW-1:0] div_divisor;
    logic [DW-1:0] div_quotient;
    logic          div_done;
    logic          div_busy;

    // Mapping datapath.
    logic signed [AW:0]    diff_a;
    logic signed [OW:0]    diff_b;
    logic signed [AW:0]    span;
    logic signed [PW-1:0]  prod_w;
    logic [PW-1:0]         prod_abs;
    logic [PW-1:0]         q_ext;
    logic signed [PW-1:0]  q_signed;
    logic                  sat_low;
    logic                  sat_high;
    logic [TW-1:0]         on_sat;
    logic signed [TW:0]    off_w;
    logic                  chan_ok;
    logic                  last_ch;
    logic                  out_free;
    logic [NUM_CHANNELS+2:0] lev_ext;
    logic [NUM_CHANNELS+2:0] tog_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign last_ch    = (r_idx == IW'(NUM_CHANNELS - 1));
    assign chan_ok    = ({3'b000, i_in.channel} < 5'(NUM_CHANNELS));

    // Signed differences and product for the linear map.
    always_comb begin
        diff_a   = $signed({1'b0, r_angle}) - $signed({1'b0, r_min_angle});
        diff_b   = $signed({1'b0, r_max_on}) - $signed({1'b0, r_min_on});
        span     = $signed({1'b0, r_max_angle}) - $signed({1'b0, r_min_angle});
        prod_w   = diff_a * diff_b;
        prod_abs = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
        q_ext    = {{(PW-DW){1'b0}}, div_quotient};
        q_signed = r_neg ? -$signed(q_ext) : $signed(q_ext);
    end

    // Divider operands: magnitudes, sign is applied to the quotient.
    assign div_start    = (r_state == S_DIVGO);
    assign div_dividend = prod_abs[DW-1:0];
    assign div_divisor  = span[AW] ? AW'(-span) : span[AW-1:0];

    // Saturate the on time to the timer range and derive the off time.
    always_comb begin
        sat_low  = r_on[PW-1];
        sat_high = !r_on[PW-1] && (r_on[PW-2:TW] != '0);
        if (sat_low) begin
            on_sat = '0;
        end else if (sat_high) begin
            on_sat = '1;
        end else begin
            on_sat = r_on[TW-1:0];
        end
        off_w = $signed({1'b0, r_frame}) - $signed({1'b0, on_sat});
    end

    // Commands to the channel store.
    always_comb begin
        chan_cmd.tick      = (r_state == S_TICK);
        chan_cmd.set       = r_wr_en;
        chan_cmd.high_time = r_wr_high;
        chan_cmd.low_time  = r_wr_low;
    end

    // Sequencer, configuration and output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_angle <= mcsp_pkg::RST_MIN_ANGLE;
            r_max_angle <= mcsp_pkg::RST_MAX_ANGLE;
            r_min_on    <= mcsp_pkg::RST_MIN_ON_TIME;
            r_max_on    <= mcsp_pkg::RST_MAX_ON_TIME;
            r_frame     <= mcsp_pkg::RST_FRAME_PERIOD;
            r_out_valid <= 1'b0;
            r_wr_en     <= 1'b0;
            r_idx       <= '0;
            r_tog       <= '0;
            r_clip      <= 1'b0;
        end else begin
            // The channel store is written once for each set-angle that changes a channel.
            r_wr_en <= (r_state == S_FIN)
                    || (r_state == S_IDLE && i_in_valid
                        && i_in.command == mcsp_pkg::CMD_SET
                        && chan_ok && i_in.angle == '0);

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mcsp_pkg::CFG_MIN_ANGLE:    r_min_angle <= i_cfg_data[AW-1:0];
                    mcsp_pkg::CFG_MAX_ANGLE:    r_max_angle <= i_cfg_data[AW-1:0];
                    mcsp_pkg::CFG_MIN_ON_TIME:  r_min_on    <= i_cfg_data[OW-1:0];
                    mcsp_pkg::CFG_MAX_ON_TIME:  r_max_on    <= i_cfg_data[OW-1:0];
                    mcsp_pkg::CFG_FRAME_PERIOD: r_frame     <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end

            // The output register fills from write-back and drains on acceptance.
            if (r_state == S_WB && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tog   <= '0;
                        r_clip  <= 1'b0;
                        r_angle <= i_in.angle;
                        if (i_in.command == mcsp_pkg::CMD_TICK) begin
                            r_idx   <= '0;
                            r_state <= S_TICK;
                        end else if (!chan_ok) begin
                            r_state <= S_WB;
                        end else begin
                            r_idx <= IW'({3'b000, i_in.channel});
                            if (i_in.angle == '0) begin
                                r_wr_high <= mcsp_pkg::ZERO_ANGLE_ON;
                                r_wr_low  <= mcsp_pkg::ZERO_ANGLE_OFF;
                                r_state   <= S_WB;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_TICK: begin
                    r_tog[r_idx] <= chan_toggle;
                    if (last_ch) begin
                        r_state <= S_WB;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL: begin
                    if (span == '0) begin
                        // Zero angle range: fall back to the minimum on time.
                        r_on    <= $signed({{(PW-OW){1'b0}}, r_min_on});
                        r_clip  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_prod  <= prod_w;
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    r_neg   <= r_prod[PW-1] ^ span[AW];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_on    <= q_signed + $signed({{(PW-OW){1'b0}}, r_min_on});
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_wr_high <= on_sat;
                    if (off_w[TW]) begin
                        r_wr_low <= '0;
                    end else begin
                        r_wr_low <= off_w[TW-1:0];
                    end
                    if (sat_low || sat_high || off_w[TW]) begin
                        r_clip <= 1'b1;
                    end
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (out_free) begin
                        r_out.pwm_levels <= lev_ext[2:0];
                        r_out.toggled    <= tog_ext[2:0];
                        r_out.clipped    <= r_clip;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Only the first three channels fit the result fields.
    assign lev_ext = {3'b000, chan_levels};
    assign tog_ext = {3'b000, r_tog};

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    mcsp_chan #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IW           (IW)
    ) u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_idx    (r_idx),
        .i_cmd    (chan_cmd),
        .o_levels (chan_levels),
        .o_toggle (chan_toggle)
    );

    mcsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_done     (div_done),
        .o_busy     (div_busy)
    );

    // The divider runs only while the sequencer waits for it.
    a_div_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    // A finished division is always taken by the divide state.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider result dropped");

    // A result never reports both toggles and a clipped set-angle.
    a_tog_clip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.clipped && (o_out.toggled != '0)))
        else $error("toggle and clip reported together");

    // A new result is loaded only into a free output register.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && r_out_valid && !i_out_ready) |=> (r_state == S_WB))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the multi-channel servo PWM block.
`timescale 1ns / 100ps

// Scoreboard: mirrors the registers and channel state, and queues the expected result words.
class servo_pwm_scoreboard;
    logic [mcsp_pkg::ANGLE_W-1:0]  min_angle;
    logic [mcsp_pkg::ANGLE_W-1:0]  max_angle;
    logic [mcsp_pkg::ONTIME_W-1:0] min_on_time;
    logic [mcsp_pkg::ONTIME_W-1:0] max_on_time;
    logic [mcsp_pkg::TIME_W-1:0]   frame_period;
    logic [mcsp_pkg::TIME_W-1:0]   high_time [mcsp_pkg::DEFAULT_NUM_CHANNELS];
    logic [mcsp_pkg::TIME_W-1:0]   low_time  [mcsp_pkg::DEFAULT_NUM_CHANNELS];
    logic [mcsp_pkg::TIME_W-1:0]   elapsed   [mcsp_pkg::DEFAULT_NUM_CHANNELS];
    logic                          level     [mcsp_pkg::DEFAULT_NUM_CHANNELS];
    mcsp_pkg::t_out_item           expected_words [$];
    int                            errors;

    function new();
        min_angle    = mcsp_pkg::RST_MIN_ANGLE;
        max_angle    = mcsp_pkg::RST_MAX_ANGLE;
        min_on_time  = mcsp_pkg::RST_MIN_ON_TIME;
        max_on_time  = mcsp_pkg::RST_MAX_ON_TIME;
        frame_period = mcsp_pkg::RST_FRAME_PERIOD;
        for (int i = 0; i < mcsp_pkg::DEFAULT_NUM_CHANNELS; i++) begin
            high_time[i] = '0;
            low_time[i]  = '0;
            elapsed[i]   = '0;
            level[i]     = 1'b0;
        end
        errors = 0;
    endfunction

    // Print one line per mismatch and count it.
    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(logic [mcsp_pkg::CFG_IDX_W-1:0] idx,
                          logic [mcsp_pkg::CFG_W-1:0] value);
        case (idx)
            mcsp_pkg::CFG_MIN_ANGLE:    min_angle    = value[mcsp_pkg::ANGLE_W-1:0];
            mcsp_pkg::CFG_MAX_ANGLE:    max_angle    = value[mcsp_pkg::ANGLE_W-1:0];
            mcsp_pkg::CFG_MIN_ON_TIME:  min_on_time  = value[mcsp_pkg::ONTIME_W-1:0];
            mcsp_pkg::CFG_MAX_ON_TIME:  max_on_time  = value[mcsp_pkg::ONTIME_W-1:0];
            mcsp_pkg::CFG_FRAME_PERIOD: frame_period = value[mcsp_pkg::TIME_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // Advance the channel state by one accepted word and queue the result it causes.
    function void note_word(mcsp_pkg::t_in_item w);
        mcsp_pkg::t_out_item exp_word;
        int        next_count;
        int        phase_len;
        longint    ang;
        longint    ang_lo;
        longint    ang_hi;
        longint    on_lo;
        longint    on_hi;
        longint    span;
        longint    on_time;
        longint    off_time;
        longint    time_max;
        exp_word = '0;
        time_max = (longint'(1) << mcsp_pkg::TIME_W) - 1;
        if (w.command == mcsp_pkg::CMD_TICK) begin
            // Every channel counts; a count past the current phase flips the level.
            for (int i = 0; i < mcsp_pkg::DEFAULT_NUM_CHANNELS; i++) begin
                next_count = elapsed[i] + 1;
                phase_len  = level[i] ? high_time[i] : low_time[i];
                if (next_count > phase_len) begin
                    level[i]   = ~level[i];
                    elapsed[i] = '0;
                    exp_word.toggled[i] = 1'b1;
                end else begin
                    elapsed[i] = next_count[mcsp_pkg::TIME_W-1:0];
                end
            end
        end else if (w.channel < mcsp_pkg::DEFAULT_NUM_CHANNELS) begin
            if (w.angle == '0) begin
                high_time[w.channel] = mcsp_pkg::ZERO_ANGLE_ON;
                low_time[w.channel]  = mcsp_pkg::ZERO_ANGLE_OFF;
            end else begin
                // Linear map of the angle onto the on-time range, quotient truncated toward zero.
                ang    = w.angle;
                ang_lo = min_angle;
                ang_hi = max_angle;
                on_lo  = min_on_time;
                on_hi  = max_on_time;
                span   = ang_hi - ang_lo;
                if (span == 0) begin
                    on_time = on_lo;
                    exp_word.clipped = 1'b1;
                end else begin
                    on_time = (ang - ang_lo) * (on_hi - on_lo) / span + on_lo;
                end
                if (on_time < 0) begin
                    on_time = 0;
                    exp_word.clipped = 1'b1;
                end else if (on_time > time_max) begin
                    on_time = time_max;
                    exp_word.clipped = 1'b1;
                end
                off_time = longint'(frame_period) - on_time;
                if (off_time < 0) begin
                    off_time = 0;
                    exp_word.clipped = 1'b1;
                end
                high_time[w.channel] = on_time[mcsp_pkg::TIME_W-1:0];
                low_time[w.channel]  = off_time[mcsp_pkg::TIME_W-1:0];
            end
        end
        for (int i = 0; i < mcsp_pkg::DEFAULT_NUM_CHANNELS; i++) begin
            exp_word.pwm_levels[i] = level[i];
        end
        expected_words.push_back(exp_word);
    endfunction

    // Compare one result word with the oldest expected word.
    task check_word(mcsp_pkg::t_out_item got);
        mcsp_pkg::t_out_item want;
        if (expected_words.size() == 0) begin
            report($sformatf("result word %b arrived with no item outstanding", got));
            return;
        end
        want = expected_words.pop_front();
        if (got.pwm_levels !== want.pwm_levels) begin
            report($sformatf("pwm_levels got %b want %b", got.pwm_levels, want.pwm_levels));
        end
        if (got.toggled !== want.toggled) begin
            report($sformatf("toggled got %b want %b", got.toggled, want.toggled));
        end
        if (got.clipped !== want.clipped) begin
            report($sformatf("clipped got %b want %b", got.clipped, want.clipped));
        end
    endtask
endclass

module tb;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 130;
    localparam int AW  = mcsp_pkg::ANGLE_W;
    localparam int OW  = mcsp_pkg::ONTIME_W;
    localparam int TW  = mcsp_pkg::TIME_W;
    localparam int CW  = mcsp_pkg::CFG_W;
    localparam int CIW = mcsp_pkg::CFG_IDX_W;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    mcsp_pkg::t_in_item   i_in        = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CIW-1:0]       i_cfg_index = mcsp_pkg::CFG_MIN_ANGLE;
    logic [CW-1:0]        i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    mcsp_pkg::t_out_item  o_out;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    servo_pwm_scoreboard sb;

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multi_channel_servo_pwm_top #(
        .NUM_CHANNELS(mcsp_pkg::DEFAULT_NUM_CHANNELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checking and the watchdog on handshake activity.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word(o_out);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[multi_channel_servo_pwm_top] ERROR");
            $finish;
        end
    end

    // Present one word, with an optional idle gap first, and wait for its acceptance.
    task automatic send_word(input mcsp_pkg::t_in_item w);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
    endtask

    task automatic send_tick();
        mcsp_pkg::t_in_item w;
        w = '0;
        w.command = mcsp_pkg::CMD_TICK;
        send_word(w);
    endtask

    task automatic send_set(input logic [1:0] ch, input logic [AW-1:0] ang);
        mcsp_pkg::t_in_item w;
        w.command = mcsp_pkg::CMD_SET;
        w.channel = ch;
        w.angle   = ang;
        send_word(w);
    endtask

    // Stop sending and let every expected word come back before going on.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_regs(input logic [AW-1:0] lo_ang, input logic [AW-1:0] hi_ang,
                              input logic [OW-1:0] lo_on, input logic [OW-1:0] hi_on,
                              input logic [TW-1:0] period);
        write_reg(mcsp_pkg::CFG_MIN_ANGLE, CW'(lo_ang));
        write_reg(mcsp_pkg::CFG_MAX_ANGLE, CW'(hi_ang));
        write_reg(mcsp_pkg::CFG_MIN_ON_TIME, CW'(lo_on));
        write_reg(mcsp_pkg::CFG_MAX_ON_TIME, CW'(hi_on));
        write_reg(mcsp_pkg::CFG_FRAME_PERIOD, CW'(period));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly short phases so channels toggle often; now and then full-range values.
    task automatic random_regs();
        logic [AW-1:0] lo_ang;
        logic [AW-1:0] hi_ang;
        logic [OW-1:0] lo_on;
        logic [OW-1:0] hi_on;
        logic [TW-1:0] period;
        lo_ang = 8'($urandom_range(0, 255));
        hi_ang = ($urandom_range(0, 7) == 0) ? lo_ang : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
            lo_on  = 16'($urandom);
            hi_on  = 16'($urandom);
            period = 20'($urandom);
        end else begin
            lo_on  = 16'($urandom_range(0, 40));
            hi_on  = 16'($urandom_range(0, 60));
            period = 20'($urandom_range(0, 120));
        end
        apply_regs(lo_ang, hi_ang, lo_on, hi_on, period);
    endtask

    // Mostly ticks; set-angle words mostly aim inside the configured angle range.
    task automatic random_word();
        mcsp_pkg::t_in_item w;
        w.command = ($urandom_range(0, 3) == 0) ? mcsp_pkg::CMD_SET : mcsp_pkg::CMD_TICK;
        w.channel = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       w.angle = '0;
            1, 2, 3: w.angle = 8'($urandom_range(0, 255));
            default: w.angle = 8'($urandom_range(sb.min_angle, sb.max_angle));
        endcase
        send_word(w);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: phase lengths are zero, so the first two ticks flip every channel.
        send_tick();
        send_tick();
        send_set(2'd0, 8'd0);
        send_set(2'd1, 8'd255);
        send_set(2'd2, 8'd180);
        send_set(2'd3, 8'd77);
        send_tick();

        // An angle range of one with a wide on-time range overflows the on time.
        quiesce();
        apply_regs(8'd0, 8'd1, 16'd0, 16'hFFFF, 20'hFFFFF);
        send_set(2'd0, 8'd255);
        send_set(2'd1, 8'd1);
        send_tick();

        // A falling on-time range drives the on time negative; the frame is zero.
        quiesce();
        apply_regs(8'd0, 8'd1, 16'hFFFF, 16'd0, 20'd0);
        send_set(2'd2, 8'd255);
        send_set(2'd0, 8'd1);
        send_set(2'd1, 8'd128);
        send_tick();
        send_tick();

        // Zero angle range, with an off time that goes negative.
        quiesce();
        apply_regs(8'd90, 8'd90, 16'd40000, 16'd3, 20'd10);
        send_set(2'd0, 8'd200);
        send_set(2'd1, 8'd0);
        send_set(2'd2, 8'd90);

        // Inverted angle range: one quotient is negative and must truncate toward zero.
        quiesce();
        apply_regs(8'd200, 8'd100, 16'd10, 16'd20, 20'd25);
        send_set(2'd0, 8'd247);
        send_set(2'd1, 8'd53);
        send_tick();
        send_tick();

        // Random phases, each with new settings and one of four idling patterns.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            quiesce();
            random_regs();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    quiesce();
                end
                random_word();
            end
        end

        quiesce();
        if (sb.errors == 0) begin
            $display("[multi_channel_servo_pwm_top] OK");
        end else begin
            $display("[multi_channel_servo_pwm_top] ERROR");
        end
        $finish;
    end
endmodule
